FILE: rtl/core/slps_pkg.sv
// ----------------------------------------------------------------------------
// Soft line pixel shader package
// Shared types and register codes for the shader core and its square root cells.
// ----------------------------------------------------------------------------
`default_nettype none

package slps_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] RegOriginX  = 3'd0;
  localparam logic [2:0] RegOriginY  = 3'd1;
  localparam logic [2:0] RegHeading  = 3'd2;
  localparam logic [2:0] RegLength   = 3'd3;
  localparam logic [2:0] RegRed      = 3'd4;
  localparam logic [2:0] RegGreen    = 3'd5;
  localparam logic [2:0] RegBlue     = 3'd6;
  localparam logic [2:0] RegFalloff  = 3'd7;

  // One root bit per cell of the square root chain
  localparam int unsigned SqSteps = 28;

  // Per-beat tag that rides along every stage
  typedef struct packed {
    logic       vld;
    logic [2:0] row;
    logic [2:0] col;
    logic       off;
  } slps_tag_t;

  // Word handed from one square root cell to the next
  typedef struct packed {
    slps_tag_t   tag;
    logic        use_perp;
    logic [13:0] perp_d;
    logic [29:0] rem;
    logic [27:0] root;
    logic [55:0] opnd;
  } slps_sq_t;

endpackage

`default_nettype wire

FILE: rtl/core/slps_if.sv
// ----------------------------------------------------------------------------
// Soft line pixel shader channels
// Valid/ready channels for pixel requests and shaded pixel results.
// ----------------------------------------------------------------------------
`default_nettype none

interface slps_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] pixel_row;
  logic [2:0] pixel_col;

  modport source (output valid, output pixel_row, output pixel_col, input ready);
  modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

interface slps_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] out_row;
  logic [2:0] out_col;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;

  modport source (output valid, output out_row, output out_col, output red_level,
                  output green_level, output blue_level, input ready);
  modport sink   (input valid, input out_row, input out_col, input red_level,
                  input green_level, input blue_level, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/soft_line_pixel_shader_top.sv
// ----------------------------------------------------------------------------
// Soft line pixel shader
// Shades one LED grid pixel by its distance to a configured soft line segment.
// ----------------------------------------------------------------------------
// Pipeline: 7 geometry stages, 28 square root cells, 9 falloff and color stages
// between an accepted request beat and its result beat.
// Throughput: one pixel per clock; the whole pipeline holds while a finished
// result waits on the output, so ready follows the output side directly.
// Reset: asynchronous, active low; clears all stage valids and loads the
// register defaults (origin 0,0, heading 0, length 5.0, white, falloff 1.0).
`default_nettype none

module soft_line_pixel_shader_top import slps_pkg::*; #(
  parameter int GRID_SIDE = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  slps_in_if.sink          pix_in,
  slps_out_if.source       pix_out
);

  localparam logic [4:0] GridLim = 5'(GRID_SIDE);
  localparam logic [1:0] Quad0 = 2'd0;
  localparam logic [1:0] Quad1 = 2'd1;
  localparam logic [1:0] Quad2 = 2'd2;
  localparam logic [1:0] Quad3 = 2'd3;

  // ---------------------------------------------------------------- config
  logic [12:0] org_x_q, org_y_q;
  logic [15:0] heading_q;
  logic [11:0] len_q, fall_q;
  logic [7:0]  red_q, green_q, blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q   <= '0;
      org_y_q   <= '0;
      heading_q <= '0;
      len_q     <= 12'd1280;
      red_q     <= 8'd255;
      green_q   <= 8'd255;
      blue_q    <= 8'd255;
      fall_q    <= 12'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegOriginX: org_x_q   <= cfg_data_i[12:0];
        RegOriginY: org_y_q   <= cfg_data_i[12:0];
        RegHeading: heading_q <= cfg_data_i;
        RegLength:  len_q     <= cfg_data_i[11:0];
        RegRed:     red_q     <= cfg_data_i[7:0];
        RegGreen:   green_q   <= cfg_data_i[7:0];
        RegBlue:    blue_q    <= cfg_data_i[7:0];
        RegFalloff: fall_q    <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- handshake
  // Advance every stage together; hold all of them while the output stalls.
  logic en, acc;
  assign en           = !pix_out.valid || pix_out.ready;
  assign pix_in.ready = en;
  assign acc          = pix_in.valid && en;

  // ------------------------------------------------------------- tag lines
  slps_tag_t tag_q  [0:6];
  slps_tag_t btag_q [0:8];
  slps_sq_t  cell_q [0:SqSteps-1];
  slps_sq_t  cell_in;
  slps_tag_t tag_new;

  always_comb begin
    tag_new.vld = acc;
    tag_new.row = pix_in.pixel_row;
    tag_new.col = pix_in.pixel_col;
    tag_new.off = ({2'b00, pix_in.pixel_row} >= GridLim) ||
                  ({2'b00, pix_in.pixel_col} >= GridLim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q  <= '{default: '0};
      btag_q <= '{default: '0};
    end else if (en) begin
      tag_q[0] <= tag_new;
      for (int i = 1; i < 7; i++) tag_q[i] <= tag_q[i-1];
      btag_q[0] <= cell_q[SqSteps-1].tag;
      for (int i = 1; i < 9; i++) btag_q[i] <= btag_q[i-1];
    end
  end

  // ------------------------------------------------ offsets and direction
  // Stages 0..3 evaluate the quarter sine for p and for one quarter minus p.
  logic signed [13:0] rx_d, ry_d;
  logic [14:0] xa_d, xb_d;
  logic [29:0] sqa, sqb;

  assign rx_d = $signed({3'b000, pix_in.pixel_row, 8'h00}) - $signed({org_x_q[12], org_x_q});
  assign ry_d = $signed({3'b000, pix_in.pixel_col, 8'h00}) - $signed({org_y_q[12], org_y_q});
  assign xa_d = {1'b0, heading_q[13:0]};
  assign xb_d = 15'd16384 - xa_d;
  assign sqa  = xa_d * xa_d;
  assign sqb  = xb_d * xb_d;

  logic signed [13:0] rx_q [0:4];
  logic signed [13:0] ry_q [0:4];
  logic [1:0]  quad_q [0:3];
  logic [14:0] xa_q [0:2];
  logic [14:0] xb_q [0:2];
  logic [14:0] xa2_q [0:1];
  logic [14:0] xb2_q [0:1];
  logic [13:0] ina_q, inb_q;
  logic [14:0] mida_q, midb_q;
  logic [15:0] sa_q, sb_q;

  logic [25:0] ma1, mb1;
  logic [28:0] ma2, mb2;
  logic [29:0] ma3, mb3;

  assign ma1 = xa2_q[0] * 11'd1160;
  assign mb1 = xb2_q[0] * 11'd1160;
  assign ma2 = xa2_q[1] * ina_q;
  assign mb2 = xb2_q[1] * inb_q;
  assign ma3 = xa_q[2] * mida_q;
  assign mb3 = xb_q[2] * midb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q[0]   <= rx_d;
      ry_q[0]   <= ry_d;
      quad_q[0] <= heading_q[15:14];
      xa_q[0]   <= xa_d;
      xb_q[0]   <= xb_d;
      xa2_q[0]  <= sqa[28:14];
      xb2_q[0]  <= sqb[28:14];
      for (int i = 1; i < 5; i++) begin
        rx_q[i] <= rx_q[i-1];
        ry_q[i] <= ry_q[i-1];
      end
      for (int i = 1; i < 4; i++) quad_q[i] <= quad_q[i-1];
      for (int i = 1; i < 3; i++) begin
        xa_q[i] <= xa_q[i-1];
        xb_q[i] <= xb_q[i-1];
      end
      xa2_q[1] <= xa2_q[0];
      xb2_q[1] <= xb2_q[0];
      ina_q    <= 14'd10512 - {2'b00, ma1[25:14]};
      inb_q    <= 14'd10512 - {2'b00, mb1[25:14]};
      mida_q   <= 15'd25736 - ma2[28:14];
      midb_q   <= 15'd25736 - mb2[28:14];
      sa_q     <= ma3[29:14];
      sb_q     <= mb3[29:14];
    end
  end

  // Rotate the quarter sines into the heading's quadrant.
  logic signed [16:0] dx, dy, sa_s, sb_s;
  assign sa_s = $signed({1'b0, sa_q});
  assign sb_s = $signed({1'b0, sb_q});

  always_comb begin
    unique case (quad_q[3])
      Quad0: begin dx = sb_s;  dy = sa_s;  end
      Quad1: begin dx = -sa_s; dy = sb_s;  end
      Quad2: begin dx = -sb_s; dy = -sa_s; end
      Quad3: begin dx = sa_s;  dy = -sb_s; end
      default: begin dx = sb_s; dy = sa_s; end
    endcase
  end

  // --------------------------------------------------- geometry products
  logic signed [12:0] len_s;
  logic signed [30:0] pdot1_d, pdot2_d, pc1_d, pc2_d;
  logic signed [27:0] prx_d, pry_d;
  logic signed [29:0] pdl_d, pyl_d;
  logic [23:0] lsq_d;

  assign len_s   = $signed({1'b0, len_q});
  assign pdot1_d = rx_q[3] * dx;
  assign pdot2_d = ry_q[3] * dy;
  assign pc1_d   = rx_q[3] * dy;
  assign pc2_d   = ry_q[3] * dx;
  assign prx_d   = rx_q[3] * rx_q[3];
  assign pry_d   = ry_q[3] * ry_q[3];
  assign pdl_d   = dx * len_s;
  assign pyl_d   = dy * len_s;
  assign lsq_d   = len_q * len_q;

  logic signed [30:0] pdot1_q, pdot2_q, pc1_q, pc2_q;
  logic [26:0] prx_q, pry_q;
  logic signed [29:0] pdl_q, pyl_q;
  logic [23:0] lsq_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pdot1_q <= pdot1_d;
      pdot2_q <= pdot2_d;
      pc1_q   <= pc1_d;
      pc2_q   <= pc2_d;
      prx_q   <= prx_d[26:0];
      pry_q   <= pry_d[26:0];
      pdl_q   <= pdl_d;
      pyl_q   <= pyl_d;
      lsq_q   <= lsq_d;
    end
  end

  // Pick the distance rule: behind the origin, past the end, or alongside.
  logic signed [31:0] dot_d, c_d;
  logic [31:0] mag_d;
  logic [26:0] r2_d;
  logic        orig_d, endp_d;
  logic signed [29:0] ex_d, ey_d;

  assign dot_d  = {pdot1_q[30], pdot1_q} + {pdot2_q[30], pdot2_q};
  assign c_d    = {pc1_q[30], pc1_q} - {pc2_q[30], pc2_q};
  assign mag_d  = c_d[31] ? -c_d : c_d;
  assign r2_d   = prx_q + pry_q;
  assign orig_d = dot_d[31] || (dot_d == 32'sd0);
  assign endp_d = !orig_d && (r2_d > {3'b000, lsq_q});
  assign ex_d   = {{2{rx_q[4][13]}}, rx_q[4], 14'h0000} - pdl_q;
  assign ey_d   = {{2{ry_q[4][13]}}, ry_q[4], 14'h0000} - pyl_q;

  logic signed [29:0] ex_q, ey_q;
  logic [26:0] r2_q [0:1];
  logic        orig_q [0:1];
  logic        perp_q [0:1];
  logic [13:0] pd_q [0:1];
  logic signed [59:0] exsq, eysq;
  logic [55:0] ex2_q, ey2_q;

  assign exsq = ex_q * ex_q;
  assign eysq = ey_q * ey_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex_q      <= ex_d;
      ey_q      <= ey_d;
      r2_q[0]   <= r2_d;
      orig_q[0] <= orig_d;
      perp_q[0] <= !orig_d && !endp_d;
      pd_q[0]   <= mag_d[27:14];
      r2_q[1]   <= r2_q[0];
      orig_q[1] <= orig_q[0];
      perp_q[1] <= perp_q[0];
      pd_q[1]   <= pd_q[0];
      ex2_q     <= exsq[55:0];
      ey2_q     <= eysq[55:0];
    end
  end

  // ------------------------------------------------------ square root chain
  // Scale the origin radius by 2^28 so both rules share one root and one shift.
  always_comb begin
    cell_in.tag      = tag_q[6];
    cell_in.use_perp = perp_q[1];
    cell_in.perp_d   = pd_q[1];
    cell_in.rem      = '0;
    cell_in.root     = '0;
    cell_in.opnd     = orig_q[1] ? {1'b0, r2_q[1], 28'h0000000} : (ex2_q + ey2_q);
  end

  for (genvar g = 0; g < SqSteps; g++) begin : g_cell
    if (g == 0) begin : g_first
      slps_sqrt_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .cell_i (cell_in),
        .cell_o (cell_q[g])
      );
    end else begin : g_next
      slps_sqrt_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .cell_i (cell_q[g-1]),
        .cell_o (cell_q[g])
      );
    end
  end

  // ------------------------------------------------------- falloff factor
  logic [13:0] seg_dist;
  logic [25:0] e_q;
  logic [42:0] tp;
  logic [15:0] f_q [0:5];
  logic [4:0]  n_q [0:5];
  logic        z_q [0:5];
  logic [9:0]  p5_q;
  logic [11:0] p4_q;
  logic [13:0] p3_q;
  logic [15:0] p2_q;
  logic [16:0] p1_q, fac_q;
  logic [22:0] m5;
  logic [25:0] m4;
  logic [27:0] m3;
  logic [29:0] m2;
  logic [31:0] m1;
  logic [24:0] mr, mg, mb;
  logic [7:0]  lr_q, lg_q, lb_q;

  assign seg_dist = cell_q[SqSteps-1].use_perp ? cell_q[SqSteps-1].perp_d
                                               : cell_q[SqSteps-1].root[27:14];
  assign tp = e_q * 17'd94548;
  assign m5 = f_q[0] * 7'd87;
  assign m4 = f_q[1] * p5_q;
  assign m3 = f_q[2] * p4_q;
  assign m2 = f_q[3] * p3_q;
  assign m1 = f_q[4] * p2_q;
  assign mr = red_q * fac_q;
  assign mg = green_q * fac_q;
  assign mb = blue_q * fac_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q    <= seg_dist * fall_q;
      f_q[0] <= tp[31:16];
      n_q[0] <= tp[36:32];
      z_q[0] <= tp[42:32] > 11'd16;
      for (int i = 1; i < 6; i++) begin
        f_q[i] <= f_q[i-1];
        n_q[i] <= n_q[i-1];
        z_q[i] <= z_q[i-1];
      end
      p5_q  <= 10'd630 - {3'b000, m5[22:16]};
      p4_q  <= 12'd3638 - {2'b00, m4[25:16]};
      p3_q  <= 14'd15743 - {2'b00, m3[27:16]};
      p2_q  <= 16'd45426 - {2'b00, m2[29:16]};
      p1_q  <= 17'd65536 - {1'b0, m1[31:16]};
      fac_q <= z_q[5] ? 17'd0 : (p1_q >> n_q[5]);
      // Drop the color for pixels off the grid.
      lr_q  <= btag_q[7].off ? 8'd0 : mr[23:16];
      lg_q  <= btag_q[7].off ? 8'd0 : mg[23:16];
      lb_q  <= btag_q[7].off ? 8'd0 : mb[23:16];
    end
  end

  // ----------------------------------------------------------------- output
  assign pix_out.valid       = btag_q[8].vld;
  assign pix_out.out_row     = btag_q[8].row;
  assign pix_out.out_col     = btag_q[8].col;
  assign pix_out.red_level   = lr_q;
  assign pix_out.green_level = lg_q;
  assign pix_out.blue_level  = lb_q;

  // ------------------------------------------------------------- assertions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_in.ready |-> (pix_out.valid && !pix_out.ready))
    else $error("input stalled without a held output beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (btag_q[8].vld && btag_q[8].off) |->
      (lr_q == 8'd0 && lg_q == 8'd0 && lb_q == 8'd0))
    else $error("off-grid pixel carries color");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_q[SqSteps-1].tag.vld |->
      (cell_q[SqSteps-1].rem <= {1'b0, cell_q[SqSteps-1].root, 1'b0}))
    else $error("square root remainder out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    btag_q[7].vld |-> (fac_q <= 17'd65536))
    else $error("falloff factor above one");

endmodule

`default_nettype wire

FILE: rtl/core/slps_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Soft line pixel shader square root cell
// One restoring square root step: brings down two operand bits, settles one root bit.
// ----------------------------------------------------------------------------
`default_nettype none

module slps_sqrt_cell import slps_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire slps_sq_t cell_i,
  output slps_sq_t      cell_o
);

  logic [29:0] rem_sh;
  logic [29:0] trial;
  slps_sq_t    nxt;

  always_comb begin
    rem_sh   = {cell_i.rem[27:0], cell_i.opnd[55:54]};
    trial    = {cell_i.root, 2'b01};
    nxt      = cell_i;
    nxt.opnd = {cell_i.opnd[53:0], 2'b00};
    if (rem_sh >= trial) begin
      nxt.rem  = rem_sh - trial;
      nxt.root = {cell_i.root[26:0], 1'b1};
    end else begin
      nxt.rem  = rem_sh;
      nxt.root = {cell_i.root[26:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_o <= '0;
    end else if (en_i) begin
      cell_o <= nxt;
    end
  end

endmodule

`default_nettype wire
